// ===== rtl/hbp_pkg.sv =====
// shared types, constants and counter helpers for the hybrid branch predictor
package hbp_pkg;

  localparam int ADDR_W    = 32;
  localparam int STAT_W    = 32;
  localparam int TAG_W     = 30;
  localparam int AGE_W     = 8;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_PRIMARY_BITS,
    REG_BIMODAL_BITS,
    REG_CHOOSER_BITS,
    REG_HISTORY_BITS,
    REG_BTB_ENABLE,
    REG_BTB_SET_BITS
  } cfg_reg_t;

  localparam logic [1:0] MODE_BIMODAL     = 2'd0;
  localparam logic [1:0] CNT_WEAK_TAKEN   = 2'd2;
  localparam logic [1:0] CNT_WEAK_BIMODAL = 2'd1;
  localparam logic [1:0] CNT_MAX          = 2'd3;

  typedef struct packed {
    logic hit;
    logic miss_taken;
  } btb_res_t;

  typedef struct packed {
    logic       pred;
    logic       used_g;
    logic       p_we;
    logic       b_we;
    logic       c_we;
    logic [1:0] p_new;
    logic [1:0] b_new;
    logic [1:0] c_new;
  } pred_res_t;

  function automatic logic [1:0] train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c != CNT_MAX) ? c + 2'd1 : c;
    end else begin
      r = (c != 2'd0) ? c - 2'd1 : c;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hybrid_branch_predictor_btb_core.sv =====
// Hybrid bimodal/gshare branch predictor with optional set-associative BTB.
// A resolved branch is taken when start is high and busy is low; one branch can
// be taken every cycle. Its result appears with done after the input register, in
// whose stage the table indexes are formed, the stage 2 registers beside the
// registered table reads, which then train the tables with one-deep write
// forwarding, and the result register. After reset, busy stays high while the
// counter tables are swept to their reset values. Config writes are taken at
// any time but belong only in idle periods. Results cannot be stalled.
module hybrid_branch_predictor_btb_core
  import hbp_pkg::*;
#(
  parameter int PRIMARY_INDEX_BITS_MAX = 14,
  parameter int BIMODAL_INDEX_BITS_MAX = 14,
  parameter int CHOOSER_INDEX_BITS_MAX = 14,
  parameter int BTB_SET_BITS_MAX       = 8,
  parameter int BTB_WAYS               = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_W-1:0]    branch_address,
  input  logic                 taken,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic                 prediction_made,
  output logic                 predicted_taken,
  output logic                 mispredicted,
  output logic                 btb_hit,
  output logic                 used_gshare,
  output logic [STAT_W-1:0]    branch_total,
  output logic [STAT_W-1:0]    predictor_miss_total,
  output logic [STAT_W-1:0]    btb_miss_taken_total,
  output logic [STAT_W-1:0]    prediction_total
);

  localparam int PW     = PRIMARY_INDEX_BITS_MAX;
  localparam int BW     = BIMODAL_INDEX_BITS_MAX;
  localparam int HW     = CHOOSER_INDEX_BITS_MAX;
  localparam int SW     = (BTB_SET_BITS_MAX > 0) ? BTB_SET_BITS_MAX : 1;
  localparam int SETS   = 1 << SW;
  localparam int CLW    = (PW > BW) ? ((PW > HW) ? PW : HW) : ((BW > HW) ? BW : HW);
  localparam int TAGS_W = BTB_WAYS * TAG_W;
  localparam int AGES_W = BTB_WAYS * AGE_W;
  localparam int ROW_W  = TAGS_W + BTB_WAYS + AGES_W;

  // configuration
  logic [1:0]       mode;
  logic [CFG_W-1:0] primary_bits;
  logic [CFG_W-1:0] bimodal_bits;
  logic [CFG_W-1:0] chooser_bits;
  logic [CFG_W-1:0] history_bits;
  logic             btb_en;
  logic [CFG_W-1:0] btb_sets_lg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BIMODAL;
      primary_bits <= 4'd12;
      bimodal_bits <= 4'd12;
      chooser_bits <= 4'd10;
      history_bits <= 4'd0;
      btb_en       <= 1'b0;
      btb_sets_lg  <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode         <= cfg_data[1:0];
        REG_PRIMARY_BITS: primary_bits <= cfg_data;
        REG_BIMODAL_BITS: bimodal_bits <= cfg_data;
        REG_CHOOSER_BITS: chooser_bits <= cfg_data;
        REG_HISTORY_BITS: history_bits <= cfg_data;
        REG_BTB_ENABLE:   btb_en       <= cfg_data[0];
        REG_BTB_SET_BITS: btb_sets_lg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [CFG_W-1:0] m, n, bm, cm, s;
  logic [PW-1:0]    pmask, hmask;
  logic [BW-1:0]    bmask;
  logic [HW-1:0]    cmask;
  logic [SW-1:0]    smask;
  logic             hybrid;

  always_comb begin
    m  = (32'(primary_bits) > PW) ? CFG_W'(PW) : primary_bits;
    n  = (history_bits > m) ? m : history_bits;
    bm = (32'(bimodal_bits) > BW) ? CFG_W'(BW) : bimodal_bits;
    cm = (32'(chooser_bits) > HW) ? CFG_W'(HW) : chooser_bits;
    s  = (32'(btb_sets_lg) > BTB_SET_BITS_MAX) ? CFG_W'(BTB_SET_BITS_MAX) : btb_sets_lg;
    pmask  = ~({PW{1'b1}} << m);
    hmask  = ~({PW{1'b1}} << n);
    bmask  = ~({BW{1'b1}} << bm);
    cmask  = ~({HW{1'b1}} << cm);
    smask  = ~({SW{1'b1}} << s);
    hybrid = mode[1];
  end

  // table clearing sweep after reset
  logic           clr_active;
  logic [CLW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + CLW'(1);
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  assign busy = clr_active;

  // stage 1: input register and index forming
  logic              v1;
  logic [ADDR_W-1:0] addr1;
  logic              taken1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    if (start && !busy) begin
      addr1  <= branch_address;
      taken1 <= taken;
    end
  end

  logic [PW-1:0]    hist, hist_next;
  logic [PW-1:0]    g1, pc_p, gidx1, pidx1;
  logic [BW-1:0]    bidx1;
  logic [HW-1:0]    cidx1;
  logic [SW-1:0]    set1;
  logic [TAG_W-1:0] tag1;

  always_comb begin
    pc_p  = addr1[2 +: PW] & pmask;
    g1    = hist_next & hmask;
    gidx1 = pc_p ^ (g1 << (m - n));
    pidx1 = (mode == MODE_BIMODAL) ? pc_p : gidx1;
    bidx1 = addr1[2 +: BW] & bmask;
    cidx1 = addr1[2 +: HW] & cmask;
    set1  = addr1[2 +: SW] & smask;
    tag1  = TAG_W'(addr1 >> (5'(s) + 5'd2));
  end

  // stage 2 registers
  logic             v2;
  logic             taken2;
  logic [PW-1:0]    pidx2;
  logic [BW-1:0]    bidx2;
  logic [HW-1:0]    cidx2;
  logic [SW-1:0]    set2;
  logic [TAG_W-1:0] tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    taken2 <= taken1;
    pidx2  <= pidx1;
    bidx2  <= bidx1;
    cidx2  <= cidx1;
    set2   <= set1;
    tag2   <= tag1;
  end

  // memories
  logic             p_we, b_we, c_we, r_we;
  logic [PW-1:0]    p_waddr;
  logic [BW-1:0]    b_waddr;
  logic [HW-1:0]    c_waddr;
  logic [1:0]       p_wdata, b_wdata, c_wdata;
  logic [1:0]       p_raw, b_raw, c_raw;
  logic [ROW_W-1:0] r_raw, r_wdata;

  hbp_ram #(.WIDTH(2), .DEPTH(1 << PW)) u_prim (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(pidx1), .rdata(p_raw)
  );
  hbp_ram #(.WIDTH(2), .DEPTH(1 << BW)) u_bim (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(bidx1), .rdata(b_raw)
  );
  hbp_ram #(.WIDTH(2), .DEPTH(1 << HW)) u_cho (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(cidx1), .rdata(c_raw)
  );
  hbp_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_btb (
    .clk(clk), .we(r_we), .waddr(set2), .wdata(r_wdata), .raddr(set1), .rdata(r_raw)
  );

  // last writes, forwarded to the next item
  logic             lwp_en, lwb_en, lwc_en, lwr_en;
  logic [PW-1:0]    lwp_addr;
  logic [BW-1:0]    lwb_addr;
  logic [HW-1:0]    lwc_addr;
  logic [SW-1:0]    lwr_set;
  logic [1:0]       lwp_data, lwb_data, lwc_data;
  logic [ROW_W-1:0] lwr_row;
  logic [SETS-1:0]  rowv;

  // stage 2 work
  logic [1:0]                    p_cnt, b_cnt, c_cnt;
  logic [ROW_W-1:0]              row_cur;
  logic [BTB_WAYS-1:0][TAG_W-1:0] row_tags, new_tags;
  logic [BTB_WAYS-1:0]           row_valid, new_valid;
  logic [BTB_WAYS-1:0][AGE_W-1:0] row_ages, new_ages;
  btb_res_t                      bres;
  pred_res_t                     pres;
  logic                          made2, hit2, pmiss2, btb_miss2;
  logic [PW-1:0]                 g2, hist_upd;

  always_comb begin
    p_cnt = (lwp_en && lwp_addr == pidx2) ? lwp_data : p_raw;
    b_cnt = (lwb_en && lwb_addr == bidx2) ? lwb_data : b_raw;
    c_cnt = (lwc_en && lwc_addr == cidx2) ? lwc_data : c_raw;
    if (lwr_en && lwr_set == set2) begin
      row_cur = lwr_row;
    end else begin
      row_cur = r_raw;
      // a row never written has no valid ways
      row_cur[TAGS_W +: BTB_WAYS] = r_raw[TAGS_W +: BTB_WAYS] & {BTB_WAYS{rowv[set2]}};
    end
    row_tags  = row_cur[0 +: TAGS_W];
    row_valid = row_cur[TAGS_W +: BTB_WAYS];
    row_ages  = row_cur[TAGS_W + BTB_WAYS +: AGES_W];
  end

  hbp_btb #(.WAYS(BTB_WAYS)) u_btb_lru (
    .tags(row_tags), .valid(row_valid), .ages(row_ages), .tag(tag2), .taken(taken2),
    .res(bres), .new_tags(new_tags), .new_valid(new_valid), .new_ages(new_ages)
  );

  hbp_pred u_pred (
    .hybrid(hybrid), .p_cnt(p_cnt), .b_cnt(b_cnt), .c_cnt(c_cnt), .taken(taken2), .res(pres)
  );

  always_comb begin
    hit2      = btb_en && bres.hit;
    made2     = !btb_en || bres.hit;
    btb_miss2 = btb_en && bres.miss_taken;
    pmiss2    = made2 && (pres.pred != taken2);
    g2        = hist & hmask;
    hist_upd  = ((g2 >> 1) | (PW'(taken2) << (n - CFG_W'(1)))) & hmask;
    hist_next = (v2 && made2 && n != '0) ? hist_upd : hist;
    r_wdata   = {new_ages, new_valid, new_tags};
    r_we      = v2 && btb_en;
    p_we      = clr_active || (v2 && made2 && pres.p_we);
    b_we      = clr_active || (v2 && made2 && pres.b_we);
    c_we      = clr_active || (v2 && made2 && pres.c_we);
    p_waddr   = clr_active ? clr_addr[PW-1:0] : pidx2;
    b_waddr   = clr_active ? clr_addr[BW-1:0] : bidx2;
    c_waddr   = clr_active ? clr_addr[HW-1:0] : cidx2;
    p_wdata   = clr_active ? CNT_WEAK_TAKEN : pres.p_new;
    b_wdata   = clr_active ? CNT_WEAK_TAKEN : pres.b_new;
    c_wdata   = clr_active ? CNT_WEAK_BIMODAL : pres.c_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lwp_en <= 1'b0;
      lwb_en <= 1'b0;
      lwc_en <= 1'b0;
      lwr_en <= 1'b0;
      rowv   <= '0;
      hist   <= '0;
    end else begin
      lwp_en <= p_we && !clr_active;
      lwb_en <= b_we && !clr_active;
      lwc_en <= c_we && !clr_active;
      lwr_en <= r_we;
      hist   <= hist_next;
      if (r_we) begin
        rowv[set2] <= 1'b1;
      end
    end
    lwp_addr <= pidx2;
    lwb_addr <= bidx2;
    lwc_addr <= cidx2;
    lwr_set  <= set2;
    lwp_data <= pres.p_new;
    lwb_data <= pres.b_new;
    lwc_data <= pres.c_new;
    lwr_row  <= r_wdata;
  end

  // result register and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      done                 <= 1'b0;
      branch_total         <= '0;
      predictor_miss_total <= '0;
      btb_miss_taken_total <= '0;
      prediction_total     <= '0;
    end else begin
      done <= v2;
      if (v2) begin
        if (branch_total != '1) begin
          branch_total <= branch_total + STAT_W'(1);
        end
        if (pmiss2 && predictor_miss_total != '1) begin
          predictor_miss_total <= predictor_miss_total + STAT_W'(1);
        end
        if (btb_miss2 && btb_miss_taken_total != '1) begin
          btb_miss_taken_total <= btb_miss_taken_total + STAT_W'(1);
        end
        if (made2 && prediction_total != '1) begin
          prediction_total <= prediction_total + STAT_W'(1);
        end
      end
    end
    prediction_made <= made2;
    predicted_taken <= made2 && pres.pred;
    mispredicted    <= pmiss2 || btb_miss2;
    btb_hit         <= hit2;
    used_gshare     <= made2 && pres.used_g;
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("result during table clear");
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> branch_total != '0) else $error("result with zero branch total");
  a_no_pred_flags: assert property (@(posedge clk) disable iff (rst)
    (done && !prediction_made) |-> (!predicted_taken && !used_gshare))
    else $error("prediction flags without a prediction");
  a_hit_means_made: assert property (@(posedge clk) disable iff (rst)
    (done && btb_hit) |-> prediction_made) else $error("btb hit without prediction");
`endif

endmodule

// ===== rtl/hbp_ram.sv =====
// generic single write port ram with registered read
module hbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hbp_btb.sv =====
// btb set lookup, lru age update and victim choice for one set
module hbp_btb
  import hbp_pkg::*;
#(
  parameter int WAYS = 4
) (
  input  logic [WAYS-1:0][TAG_W-1:0] tags,
  input  logic [WAYS-1:0]            valid,
  input  logic [WAYS-1:0][AGE_W-1:0] ages,
  input  logic [TAG_W-1:0]           tag,
  input  logic                       taken,
  output btb_res_t                   res,
  output logic [WAYS-1:0][TAG_W-1:0] new_tags,
  output logic [WAYS-1:0]            new_valid,
  output logic [WAYS-1:0][AGE_W-1:0] new_ages
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic           hit;
  logic [WW-1:0]  hway;
  logic           free;
  logic [WW-1:0]  fway;
  logic [WW-1:0]  oway;
  logic [AGE_W-1:0] oage;
  logic [WW-1:0]  victim;
  logic [AGE_W-1:0] old;

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    free = 1'b0;
    fway = '0;
    oway = '0;
    oage = ages[0];
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && valid[i] && tags[i] == tag) begin
        hit  = 1'b1;
        hway = WW'(i);
      end
      if (!free && !valid[i]) begin
        free = 1'b1;
        fway = WW'(i);
      end
    end
    // oldest way, lowest way wins a tie
    for (int i = 1; i < WAYS; i++) begin
      if (ages[i] > oage) begin
        oage = ages[i];
        oway = WW'(i);
      end
    end
    victim    = free ? fway : oway;
    old       = ages[hway];
    new_tags  = tags;
    new_valid = valid;
    new_ages  = ages;
    for (int i = 0; i < WAYS; i++) begin
      if (hit) begin
        if (WW'(i) == hway) begin
          new_ages[i] = '0;
        end else if (valid[i] && ages[i] < old) begin
          new_ages[i] = ages[i] + AGE_W'(1);
        end
      end else begin
        if (WW'(i) == victim) begin
          new_tags[i]  = tag;
          new_valid[i] = 1'b1;
          new_ages[i]  = '0;
        end else if (valid[i] && ages[i] != '1) begin
          new_ages[i] = ages[i] + AGE_W'(1);
        end
      end
    end
    res.hit        = hit;
    res.miss_taken = !hit && taken;
  end

endmodule

// ===== rtl/hbp_pred.sv =====
// counter prediction and training for bimodal, gshare and hybrid modes
module hbp_pred
  import hbp_pkg::*;
(
  input  logic       hybrid,
  input  logic [1:0] p_cnt,
  input  logic [1:0] b_cnt,
  input  logic [1:0] c_cnt,
  input  logic       taken,
  output pred_res_t  res
);

  logic gp;
  logic bp;

  always_comb begin
    gp  = p_cnt[1];
    bp  = b_cnt[1];
    res = '0;
    res.p_new = train(p_cnt, taken);
    res.b_new = train(b_cnt, taken);
    res.c_new = c_cnt;
    if (!hybrid) begin
      res.pred = gp;
      res.p_we = 1'b1;
    end else begin
      res.used_g = c_cnt[1];
      if (c_cnt[1]) begin
        res.pred = gp;
        res.p_we = 1'b1;
      end else begin
        res.pred = bp;
        res.b_we = 1'b1;
      end
      // chooser moves toward the component that alone was right
      if (gp == taken && bp != taken) begin
        res.c_new = train(c_cnt, 1'b1);
        res.c_we  = 1'b1;
      end else if (bp == taken && gp != taken) begin
        res.c_new = train(c_cnt, 1'b0);
        res.c_we  = 1'b1;
      end
    end
  end

endmodule

// ===== tb/hybrid_branch_predictor_btb_core_tb.sv =====
// testbench for the hybrid branch predictor core: scored random and directed branch streams
`timescale 1ns / 1ps

module hybrid_branch_predictor_btb_core_tb;
  import hbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int NPHASE = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    bit        made;
    bit        pred;
    bit        miss;
    bit        hit;
    bit        used_g;
    bit [31:0] total;
    bit [31:0] pmiss;
    bit [31:0] bmiss;
    bit [31:0] preds;
  } outcome_t;

  class branch_scoreboard;
    bit [1:0]  prim[16384];
    bit [1:0]  bim[16384];
    bit [1:0]  cho[16384];
    bit [13:0] hist;
    bit [29:0] tags[256][4];
    bit        vld[256][4];
    bit [7:0]  ages[256][4];
    bit [31:0] stats[4];
    bit [3:0]  regs[8];
    outcome_t  pending[$];
    int        errors;
    int        checked;

    function new();
      foreach (prim[i]) begin
        prim[i] = CNT_WEAK_TAKEN;
        bim[i] = CNT_WEAK_TAKEN;
        cho[i] = CNT_WEAK_BIMODAL;
      end
      foreach (vld[i, j]) begin
        vld[i][j] = 0;
        ages[i][j] = 0;
        tags[i][j] = 0;
      end
      hist = 0;
      foreach (stats[i]) stats[i] = 0;
      regs[REG_MODE] = 0;
      regs[REG_PRIMARY_BITS] = 12;
      regs[REG_BIMODAL_BITS] = 12;
      regs[REG_CHOOSER_BITS] = 10;
      regs[REG_HISTORY_BITS] = 0;
      regs[REG_BTB_ENABLE] = 0;
      regs[REG_BTB_SET_BITS] = 4;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [3:0] val);
      case (idx)
        REG_MODE: regs[idx] = val & 4'h3;
        REG_BTB_ENABLE: regs[idx] = val & 4'h1;
        REG_NONE: ;
        default: regs[idx] = val;
      endcase
    endfunction

    function bit [1:0] bump(bit [1:0] c, bit up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function int unsigned clampw(bit [3:0] v, int unsigned lim);
      return (v > lim) ? lim : v;
    endfunction

    function void sat(int k);
      if (stats[k] != 32'hFFFFFFFF) stats[k]++;
    endfunction

    // work out the result of one accepted branch and queue it
    function void note_branch(bit [31:0] addr, bit t);
      outcome_t o;
      int unsigned m, n, s, setn, way, victim, bi, ci;
      bit [31:0] pc, tag, g, gidx, idx;
      bit found, gp, bp;
      bit [7:0] old;
      m = clampw(regs[REG_PRIMARY_BITS], 14);
      n = clampw(regs[REG_HISTORY_BITS], m);
      pc = addr >> 2;
      o = '{made: 1, default: 0};
      sat(0);
      if (regs[REG_BTB_ENABLE][0]) begin
        s = clampw(regs[REG_BTB_SET_BITS], 8);
        setn = pc & ((32'd1 << s) - 1);
        tag = addr >> (s + 2);
        for (int i = 0; i < 4; i++)
          if (!o.hit && vld[setn][i] && tags[setn][i] == tag[29:0]) begin
            o.hit = 1;
            way = i;
          end
        if (o.hit) begin
          old = ages[setn][way];
          ages[setn][way] = 0;
          for (int i = 0; i < 4; i++)
            if (i != way && vld[setn][i] && ages[setn][i] < old) ages[setn][i]++;
        end else begin
          o.made = 0;
          if (t) begin
            o.miss = 1;
            sat(2);
          end
          found = 0;
          victim = 0;
          for (int i = 0; i < 4; i++)
            if (!found && !vld[setn][i]) begin
              found = 1;
              victim = i;
            end
          if (!found) begin
            old = ages[setn][0];
            for (int i = 1; i < 4; i++)
              if (ages[setn][i] > old) begin
                old = ages[setn][i];
                victim = i;
              end
          end
          tags[setn][victim] = tag[29:0];
          vld[setn][victim] = 1;
          ages[setn][victim] = 0;
          for (int i = 0; i < 4; i++)
            if (i != victim && vld[setn][i] && ages[setn][i] != 8'd255) ages[setn][i]++;
        end
      end
      if (o.made) begin
        g = hist & ((32'd1 << n) - 1);
        gidx = (pc & ((32'd1 << m) - 1)) ^ (g << (m - n));
        sat(3);
        if (!regs[REG_MODE][1]) begin
          idx = (regs[REG_MODE] == 1) ? gidx : (pc & ((32'd1 << m) - 1));
          o.pred = prim[idx] >= 2;
          prim[idx] = bump(prim[idx], t);
        end else begin
          bi = pc & ((32'd1 << clampw(regs[REG_BIMODAL_BITS], 14)) - 1);
          ci = pc & ((32'd1 << clampw(regs[REG_CHOOSER_BITS], 14)) - 1);
          gp = prim[gidx] >= 2;
          bp = bim[bi] >= 2;
          o.used_g = cho[ci] >= 2;
          if (o.used_g) begin
            o.pred = gp;
            prim[gidx] = bump(prim[gidx], t);
          end else begin
            o.pred = bp;
            bim[bi] = bump(bim[bi], t);
          end
          if (gp == t && bp != t) cho[ci] = bump(cho[ci], 1);
          else if (bp == t && gp != t) cho[ci] = bump(cho[ci], 0);
        end
        if (o.pred != t) begin
          o.miss = 1;
          sat(1);
        end
        if (n > 0) hist = ((g >> 1) | (32'(t) << (n - 1))) & ((32'd1 << n) - 1);
      end
      o.total = stats[0];
      o.pmiss = stats[1];
      o.bmiss = stats[2];
      o.preds = stats[3];
      pending.push_back(o);
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(outcome_t r);
      outcome_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t result with nothing pending", $realtime);
        errors++;
      end else begin
        e = pending.pop_front();
        if (r.made != e.made) report("prediction_made", r.made, e.made);
        if (r.pred != e.pred) report("predicted_taken", r.pred, e.pred);
        if (r.miss != e.miss) report("mispredicted", r.miss, e.miss);
        if (r.hit != e.hit) report("btb_hit", r.hit, e.hit);
        if (r.used_g != e.used_g) report("used_gshare", r.used_g, e.used_g);
        if (r.total != e.total) report("branch_total", r.total, e.total);
        if (r.pmiss != e.pmiss) report("predictor_miss_total", r.pmiss, e.pmiss);
        if (r.bmiss != e.bmiss) report("btb_miss_taken_total", r.bmiss, e.bmiss);
        if (r.preds != e.preds) report("prediction_total", r.preds, e.preds);
      end
    endtask
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 start = 0;
  logic                 busy;
  logic [ADDR_W-1:0]    branch_address = '0;
  logic                 taken = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 done;
  logic                 prediction_made, predicted_taken, mispredicted, btb_hit, used_gshare;
  logic [STAT_W-1:0]    branch_total, predictor_miss_total, btb_miss_taken_total;
  logic [STAT_W-1:0]    prediction_total;

  branch_scoreboard sb = new();
  int sent = 0;
  bit [31:0] pool[16];

  hybrid_branch_predictor_btb_core dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{prediction_made, predicted_taken, mispredicted, btb_hit, used_gshare,
                        branch_total, predictor_miss_total, btb_miss_taken_total,
                        prediction_total});
  end

  // called at a falling edge; returns at a falling edge with start still high
  task send_branch(bit [31:0] addr, bit t, bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    branch_address = addr;
    taken = t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_branch(addr, t);
    sent++;
    @(negedge clk);
  endtask

  // let every pending result arrive before touching the registers
  task settle;
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task setup(bit [3:0] mode, bit [3:0] pb, bit [3:0] bb, bit [3:0] cb, bit [3:0] hb,
             bit [3:0] be, bit [3:0] sbits);
    settle();
    write_reg(REG_MODE, mode);
    write_reg(REG_PRIMARY_BITS, pb);
    write_reg(REG_BIMODAL_BITS, bb);
    write_reg(REG_CHOOSER_BITS, cb);
    write_reg(REG_HISTORY_BITS, hb);
    write_reg(REG_BTB_ENABLE, be);
    write_reg(REG_BTB_SET_BITS, sbits);
  endtask

  // mostly a small set of hot branches with biased outcomes, some noise
  task random_phase(int count);
    bit [31:0] a;
    int k;
    foreach (pool[i]) pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom();
        send_branch(a, 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        k = $urandom_range(0, 15);
        send_branch(pool[k], (k < 8) ? ($urandom_range(0, 7) != 0) :
                    (k < 12) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1)),
                    $urandom_range(0, 5) == 0);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 0;
    // directed: reset settings, address extremes, saturating one counter both ways
    send_branch(32'h0000_0000, 1, 0);
    send_branch(32'hFFFF_FFFF, 0, 1);
    repeat (4) send_branch(32'h0000_1004, 0, 1);
    repeat (4) send_branch(32'h0000_1004, 1, 0);
    send_branch(32'hAAAA_AAAA, 1, 1);
    send_branch(32'h5555_5555, 0, 0);
    // mode three, oversize widths and the BTB at its largest, then an ignored register index
    setup(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h1, 4'hF);
    write_reg(REG_NONE, 4'h0);
    repeat (3) send_branch(32'h0000_0040, 1, 1);
    repeat (3) send_branch(32'hFFFF_FFC0, 0, 0);
    for (int i = 0; i < 5; i++) send_branch(32'h0001_0000 + (i << 10), 1, 1);
    repeat (2) send_branch(32'h0001_0000, 1, 1);
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: setup(0, 1, 1, 1, 0, 0, 0);
        1: setup(1, 14, 1, 1, 14, 0, 0);
        2: setup(1, 0, 0, 0, 0, 1, 0);
        3: setup(2, 4, 1, 14, 3, 1, 0);
        4: setup(3, 10, 15, 15, 8, 1, 15);
        5: setup(0, 6, 4, 4, 2, 1, 2);
        6: setup(1, 8, 4, 4, 15, 1, 4);
        default: setup(2, 12, 12, 10, 6, 0, 4);
      endcase
      random_phase(PHASE_ITEMS);
    end
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    $display("sent %0d branches, checked %0d results over %0d register settings",
             sent, sb.checked, NPHASE + 2);
    $display("modes bimodal, gshare, hybrid and unused code, with and without the BTB");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
